// ===== design/ulsan_pkg.sv =====
`timescale 1ns / 1ps

package ulsan_pkg;

  // Replacement character U+FFFD as UTF-8
  localparam logic [7:0] RPL_B0 = 8'hEF;
  localparam logic [7:0] RPL_B1 = 8'hBF;
  localparam logic [7:0] RPL_B2 = 8'hBD;

  // Lead byte bounds
  localparam logic [7:0] ASCII_TOP  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] LEAD_E0    = 8'hE0;
  localparam logic [7:0] LEAD_ED    = 8'hED;
  localparam logic [7:0] LEAD_F0    = 8'hF0;
  localparam logic [7:0] LEAD_F4    = 8'hF4;

  // Continuation ranges
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] E0_LO      = 8'hA0;
  localparam logic [7:0] ED_HI      = 8'h9F;
  localparam logic [7:0] F0_LO      = 8'h90;
  localparam logic [7:0] F4_HI      = 8'h8F;

  localparam int unsigned MAX_BURST = 6;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  typedef struct packed {
    lead_kind_t  kind;
    logic [1:0]  need;
    logic [7:0]  lo;
    logic [7:0]  hi;
  } lead_info_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_end;
  } out_beat_t;

  // All output bytes caused by one input byte
  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } burst_t;

endpackage

// ===== design/utf8_lossy_sanitizer_unit.sv =====
`timescale 1ns / 1ps

// Streaming UTF-8 sanitizer: raw bytes in, always-valid UTF-8 out, with each
// maximal ill-formed subpart replaced by EF BF BD. One input beat is taken per
// cycle while the burst queue has room; a byte that holds part of a sequence
// produces nothing, otherwise it produces a burst of 1 to 6 output beats.
// The output side sends one beat per cycle while out_stall is low, so sustained
// throughput is one input byte per cycle for text whose bursts average one
// byte, and a byte that causes k beats holds the output until all k are sent.
// QUEUE_DEPTH bursts are buffered between the classifier and the serializer;
// when it fills, in_stall rises. out_last marks the last beat caused by one
// input byte, out_end the last beat of a string.
module utf8_lossy_sanitizer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ulsan_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ulsan_pkg::out_beat_t out_data
);

  logic              accept;
  logic              push;
  ulsan_pkg::burst_t push_data;
  logic              full;
  logic              pop;
  logic              head_valid;
  ulsan_pkg::burst_t head_data;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  ulsan_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  ulsan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  ulsan_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== design/ulsan_front.sv =====
`timescale 1ns / 1ps

module ulsan_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ulsan_pkg::in_beat_t in_data,
  output logic              push,
  output ulsan_pkg::burst_t push_data
);

  logic [1:0]       need_r, need_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [2:0][7:0]  held_r, held_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;

  logic [5:0][7:0]  b;
  logic [2:0]       n;
  logic [7:0]       x;
  logic             mismatch;
  logic             as_lead;
  ulsan_pkg::lead_info_t li;

  function automatic ulsan_pkg::lead_info_t decode_lead(input logic [7:0] v);
    ulsan_pkg::lead_info_t r;
    r.kind = ulsan_pkg::LEAD_BAD;
    r.need = 2'd0;
    r.lo   = ulsan_pkg::CONT_LO;
    r.hi   = ulsan_pkg::CONT_HI;
    if (v <= ulsan_pkg::ASCII_TOP) begin
      r.kind = ulsan_pkg::LEAD_ASCII;
    end else if (v >= ulsan_pkg::LEAD2_LO && v <= ulsan_pkg::LEAD2_HI) begin
      r.kind = ulsan_pkg::LEAD_TWO;
      r.need = 2'd1;
    end else if (v >= ulsan_pkg::LEAD3_LO && v <= ulsan_pkg::LEAD3_HI) begin
      r.kind = ulsan_pkg::LEAD_THREE;
      r.need = 2'd2;
      if (v == ulsan_pkg::LEAD_E0) r.lo = ulsan_pkg::E0_LO;
      if (v == ulsan_pkg::LEAD_ED) r.hi = ulsan_pkg::ED_HI;
    end else if (v >= ulsan_pkg::LEAD4_LO && v <= ulsan_pkg::LEAD4_HI) begin
      r.kind = ulsan_pkg::LEAD_FOUR;
      r.need = 2'd3;
      if (v == ulsan_pkg::LEAD_F0) r.lo = ulsan_pkg::F0_LO;
      if (v == ulsan_pkg::LEAD_F4) r.hi = ulsan_pkg::F4_HI;
    end
    return r;
  endfunction

  always_comb begin
    x        = in_data.in_byte;
    li       = decode_lead(x);
    b        = '0;
    n        = 3'd0;
    need_nxt = need_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;

    mismatch = (need_r != 2'd0) && ((x < lo_r) || (x > hi_r));
    as_lead  = (need_r == 2'd0) || mismatch;

    if (mismatch) begin
      b[n] = ulsan_pkg::RPL_B0; n = n + 3'd1;
      b[n] = ulsan_pkg::RPL_B1; n = n + 3'd1;
      b[n] = ulsan_pkg::RPL_B2; n = n + 3'd1;
      need_nxt = 2'd0;
      hcnt_nxt = 2'd0;
      lo_nxt   = ulsan_pkg::CONT_LO;
      hi_nxt   = ulsan_pkg::CONT_HI;
    end

    if (as_lead) begin
      unique case (li.kind)
        ulsan_pkg::LEAD_ASCII: begin
          b[n] = x; n = n + 3'd1;
        end
        ulsan_pkg::LEAD_BAD: begin
          b[n] = ulsan_pkg::RPL_B0; n = n + 3'd1;
          b[n] = ulsan_pkg::RPL_B1; n = n + 3'd1;
          b[n] = ulsan_pkg::RPL_B2; n = n + 3'd1;
        end
        default: begin
          held_nxt[0] = x;
          hcnt_nxt    = 2'd1;
          need_nxt    = li.need;
          lo_nxt      = li.lo;
          hi_nxt      = li.hi;
        end
      endcase
    end else begin
      need_nxt = need_r - 2'd1;
      lo_nxt   = ulsan_pkg::CONT_LO;
      hi_nxt   = ulsan_pkg::CONT_HI;
      if (need_nxt == 2'd0) begin
        // sequence complete: release held bytes, then this one
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < hcnt_r) begin
            b[n] = held_r[k];
            n = n + 3'd1;
          end
        end
        b[n] = x; n = n + 3'd1;
        hcnt_nxt = 2'd0;
      end else begin
        held_nxt[hcnt_r] = x;
        hcnt_nxt = hcnt_r + 2'd1;
      end
    end

    if (in_data.in_last) begin
      if (need_nxt != 2'd0) begin
        b[n] = ulsan_pkg::RPL_B0; n = n + 3'd1;
        b[n] = ulsan_pkg::RPL_B1; n = n + 3'd1;
        b[n] = ulsan_pkg::RPL_B2; n = n + 3'd1;
      end
      need_nxt = 2'd0;
      hcnt_nxt = 2'd0;
      lo_nxt   = ulsan_pkg::CONT_LO;
      hi_nxt   = ulsan_pkg::CONT_HI;
    end
  end

  assign push           = accept && (n != 3'd0);
  assign push_data.bytes = b;
  assign push_data.cnt   = n;
  assign push_data.last  = in_data.in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      hcnt_r <= 2'd0;
      lo_r   <= ulsan_pkg::CONT_LO;
      hi_r   <= ulsan_pkg::CONT_HI;
    end else if (accept) begin
      need_r <= need_nxt;
      hcnt_r <= hcnt_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

  // a pending sequence always has its lead held
  a_hold_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r == 2'd0) == (hcnt_r == 2'd0))
    else $error("held count out of step with pending continuations");

  // held bytes plus pending continuations never exceed a four-byte sequence
  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r != 2'd0) |-> (({1'b0, need_r} + {1'b0, hcnt_r}) <= 3'd4))
    else $error("held bytes exceed sequence length");

endmodule

// ===== design/ulsan_queue.sv =====
`timescale 1ns / 1ps

module ulsan_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ulsan_pkg::burst_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ulsan_pkg::burst_t head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ulsan_pkg::burst_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("burst pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_data.cnt != 3'd0 && push_data.cnt <= 3'(ulsan_pkg::MAX_BURST)))
    else $error("burst length out of range");

endmodule

// ===== design/ulsan_back.sv =====
`timescale 1ns / 1ps

module ulsan_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  ulsan_pkg::burst_t    head_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ulsan_pkg::out_beat_t out_data
);

  logic [2:0] idx_r, idx_nxt;
  logic       final_one;
  logic       take;

  assign final_one = (idx_r == 3'(head_data.cnt - 3'd1));
  assign out_valid = head_valid;
  assign take      = out_valid && !out_stall;
  assign pop       = take && final_one;

  assign out_data.out_byte = head_data.bytes[idx_r];
  assign out_data.out_last = final_one;
  assign out_data.out_end  = final_one && head_data.last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = final_one ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < head_data.cnt))
    else $error("byte index past end of burst");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int RAW_TARGET  = 272;     // directed bytes plus random strings
  localparam int QUIET_FROM  = 240;     // no random gaps or output stalls past this byte
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 32;

  // Directed strings, {last, byte}
  localparam logic [8:0] DIRECTED [25] = '{
    9'h100, 9'h17F, 9'h180, 9'h1FF,                 // ASCII extremes, bad leads
    9'h0C2, 9'h180, 9'h0DF, 9'h1BF,                 // two-byte extremes
    9'h0E0, 9'h0A0, 9'h180,                         // E0 at its lowest continuation
    9'h0E0, 9'h19F,                                 // E0 mismatch, bad lead retry
    9'h0ED, 9'h1A0,                                 // ED above its surrogate bound
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,                 // highest code point
    9'h0E1, 9'h180,                                 // truncated at end of string
    9'h0C2, 9'h141,                                 // ASCII breaks a sequence
    9'h1F5, 9'h1C1                                  // out-of-range leads
  };

  typedef struct {
    ulsan_pkg::in_beat_t beat;
    int                  gap;
    bit                  drain;
  } raw_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  ulsan_pkg::in_beat_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ulsan_pkg::out_beat_t out_data;

  raw_item_t             raw_q[$];
  ulsan_pkg::out_beat_t  clean_q[$];
  logic [7:0]            burst_q[$];
  int                    raw_total;
  int                    bytes_taken = 0;
  logic                  drained = 1'b1;
  int                    n_err = 0;
  int                    stall_left;

  // Predictor state
  logic [1:0] cont_left;
  logic [7:0] cont_lo;
  logic [7:0] cont_hi;
  logic [7:0] held [3];
  logic [1:0] held_n;

  utf8_lossy_sanitizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function void add_raw(input logic [7:0] b, input bit last, input bit drain);
    raw_item_t it;
    it.beat.in_byte = b;
    it.beat.in_last = last;
    it.drain = drain;
    it.gap = (raw_q.size() < QUIET_FROM && $urandom_range(0, 4) == 0) ?
             $urandom_range(1, 12) : 0;
    raw_q.insert(raw_q.size(), it);
  endfunction

  function void add_burst(input logic [7:0] v);
    burst_q.insert(burst_q.size(), v);
  endfunction

  function void push_replacement();
    add_burst(ulsan_pkg::RPL_B0);
    add_burst(ulsan_pkg::RPL_B1);
    add_burst(ulsan_pkg::RPL_B2);
  endfunction

  function void seq_idle();
    cont_left = '0;
    held_n = '0;
    cont_lo = ulsan_pkg::CONT_LO;
    cont_hi = ulsan_pkg::CONT_HI;
  endfunction

  function void hold_lead(input logic [7:0] x, input logic [1:0] extra,
                          input logic [7:0] lo, input logic [7:0] hi);
    held[0] = x;
    held_n = 2'd1;
    cont_left = extra;
    cont_lo = lo;
    cont_hi = hi;
  endfunction

  function void open_lead(input logic [7:0] x);
    if (x <= ulsan_pkg::ASCII_TOP) begin
      add_burst(x);
    end else if (x >= ulsan_pkg::LEAD2_LO && x <= ulsan_pkg::LEAD2_HI) begin
      hold_lead(x, 2'd1, ulsan_pkg::CONT_LO, ulsan_pkg::CONT_HI);
    end else if (x >= ulsan_pkg::LEAD3_LO && x <= ulsan_pkg::LEAD3_HI) begin
      hold_lead(x, 2'd2, (x == ulsan_pkg::LEAD_E0) ? ulsan_pkg::E0_LO : ulsan_pkg::CONT_LO,
                (x == ulsan_pkg::LEAD_ED) ? ulsan_pkg::ED_HI : ulsan_pkg::CONT_HI);
    end else if (x >= ulsan_pkg::LEAD4_LO && x <= ulsan_pkg::LEAD4_HI) begin
      hold_lead(x, 2'd3, (x == ulsan_pkg::LEAD_F0) ? ulsan_pkg::F0_LO : ulsan_pkg::CONT_LO,
                (x == ulsan_pkg::LEAD_F4) ? ulsan_pkg::F4_HI : ulsan_pkg::CONT_HI);
    end else begin
      push_replacement();
    end
  endfunction

  // Work out the sanitized bytes one raw byte releases
  function void sanitize_byte(input ulsan_pkg::in_beat_t b);
    int k;
    ulsan_pkg::out_beat_t o;
    burst_q.delete();
    if (cont_left == 0) begin
      open_lead(b.in_byte);
    end else if (b.in_byte < cont_lo || b.in_byte > cont_hi) begin
      // replace the held part, then retry the byte as a lead
      push_replacement();
      seq_idle();
      open_lead(b.in_byte);
    end else begin
      cont_left = cont_left - 2'd1;
      cont_lo = ulsan_pkg::CONT_LO;
      cont_hi = ulsan_pkg::CONT_HI;
      if (cont_left == 0) begin
        for (k = 0; k < held_n; k++) add_burst(held[k]);
        add_burst(b.in_byte);
        held_n = '0;
      end else begin
        held[held_n] = b.in_byte;
        held_n = held_n + 2'd1;
      end
    end
    if (b.in_last) begin
      if (cont_left != 0) push_replacement();
      seq_idle();
    end
    for (k = 0; k < burst_q.size(); k++) begin
      o.out_byte = burst_q[k];
      o.out_last = (k == burst_q.size() - 1);
      o.out_end = (k == burst_q.size() - 1) && b.in_last;
      clean_q.insert(clean_q.size(), o);
    end
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall) begin
      if (raw_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (raw_q[0].drain && (in_valid || !drained)) begin
        // hold off until every sanitized byte is out
        in_valid <= 1'b0;
      end else if (raw_q[0].gap != 0) begin
        raw_q[0].gap = raw_q[0].gap - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_data <= raw_q[0].beat;
        void'(raw_q.pop_front());
      end
    end
  end

  // Output stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (bytes_taken >= QUIET_FROM) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on accepted input beats, check output beats
  always @(posedge clk) begin
    ulsan_pkg::out_beat_t want;
    if (!rst_n) begin
      seq_idle();
      held[0] = '0;
      held[1] = '0;
      held[2] = '0;
      clean_q.delete();
      drained <= 1'b1;
      bytes_taken <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        sanitize_byte(in_data);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (clean_q.size() == 0) begin
          $error("out_byte %h arrived with nothing expected", out_data.out_byte);
          n_err++;
        end else begin
          want = clean_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            n_err++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last: expected %b, got %b", want.out_last, out_data.out_last);
            n_err++;
          end
          if (out_data.out_end !== want.out_end) begin
            $error("out_end: expected %b, got %b", want.out_end, out_data.out_end);
            n_err++;
          end
        end
      end
      drained <= (clean_q.size() == 0);
    end
  end

  initial begin
    logic [7:0] str[$];
    logic [7:0] lead;
    int         n_chars;
    int         pos;
    int         i;
    int         cycle_cnt;
    bit         timed_out;
    bit         first_str;

    for (i = 0; i < 25; i++) add_raw(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);

    first_str = 1'b1;
    while (raw_q.size() < RAW_TARGET) begin
      str.delete();
      n_chars = $urandom_range(1, 6);
      for (i = 0; i < n_chars; i++) begin
        case ($urandom_range(1, 4))
          1: str.insert(str.size(), 8'($urandom_range(0, 8'h7F)));
          2: begin
            str.insert(str.size(),
                       8'($urandom_range(ulsan_pkg::LEAD2_LO, ulsan_pkg::LEAD2_HI)));
            str.insert(str.size(),
                       8'($urandom_range(ulsan_pkg::CONT_LO, ulsan_pkg::CONT_HI)));
          end
          3: begin
            lead = 8'($urandom_range(ulsan_pkg::LEAD3_LO, ulsan_pkg::LEAD3_HI));
            str.insert(str.size(), lead);
            str.insert(str.size(), 8'($urandom_range(
                (lead == ulsan_pkg::LEAD_E0) ? ulsan_pkg::E0_LO : ulsan_pkg::CONT_LO,
                (lead == ulsan_pkg::LEAD_ED) ? ulsan_pkg::ED_HI : ulsan_pkg::CONT_HI)));
            str.insert(str.size(),
                       8'($urandom_range(ulsan_pkg::CONT_LO, ulsan_pkg::CONT_HI)));
          end
          default: begin
            lead = 8'($urandom_range(ulsan_pkg::LEAD4_LO, ulsan_pkg::LEAD4_HI));
            str.insert(str.size(), lead);
            str.insert(str.size(), 8'($urandom_range(
                (lead == ulsan_pkg::LEAD_F0) ? ulsan_pkg::F0_LO : ulsan_pkg::CONT_LO,
                (lead == ulsan_pkg::LEAD_F4) ? ulsan_pkg::F4_HI : ulsan_pkg::CONT_HI)));
            str.insert(str.size(),
                       8'($urandom_range(ulsan_pkg::CONT_LO, ulsan_pkg::CONT_HI)));
            str.insert(str.size(),
                       8'($urandom_range(ulsan_pkg::CONT_LO, ulsan_pkg::CONT_HI)));
          end
        endcase
      end
      // break about a third of the strings
      if ($urandom_range(0, 2) == 0) begin
        pos = $urandom_range(0, str.size() - 1);
        case ($urandom_range(0, 3))
          0: str[pos] = 8'($urandom_range(0, 255));
          1: while (str.size() > pos + 1) void'(str.pop_back());
          2: str.insert(pos, 8'($urandom_range(0, 255)));
          default: begin
            str.delete();
            for (i = 0; i < 1 + pos; i++) str.insert(str.size(), 8'($urandom_range(0, 255)));
          end
        endcase
      end
      for (i = 0; i < str.size(); i++)
        add_raw(str[i], i == str.size() - 1,
                i == 0 && (first_str || $urandom_range(0, 7) == 0));
      first_str = 1'b0;
    end
    raw_total = raw_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    cycle_cnt = 0;
    timed_out = 1'b0;
    while (!(bytes_taken == raw_total && drained) && !timed_out) begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("Testbench completed WITH ERRORS");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      @(negedge clk);
      if (clean_q.size() != 0) begin
        $error("%0d sanitized bytes never arrived", clean_q.size());
        n_err++;
      end
      if (n_err == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
    end
    $finish;
  end

endmodule
